FILE: design/wnpp_pkg.sv
`timescale 1ns / 1ps

package wnpp_pkg;

   // fixed field widths
   localparam int IDX_W    = 10;
   localparam int CFG_W    = 11;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // parameter defaults
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_COORD_BITS = 24;

   // request kinds
   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LENGTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_WINDOW = 1'b1;

   // reset values of the registers
   localparam logic [CFG_W-1:0] RST_PATH_LENGTH   = 11'd0;
   localparam logic [CFG_W-1:0] RST_SEARCH_WINDOW = 11'd32;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } seq_state_type;

endpackage

FILE: design/windowed_nearest_path_point_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// request   start / busy              req_type, req_load_index, req_start_index,
//                                     req_coord_x, req_coord_y
// result    rsp_valid (1-cycle pulse) rsp_nearest_index, rsp_status
// csr       csr_we                    csr_index, csr_wdata
//
// A store, a rejected query or a zero-window query answers in the cycle after
// it is taken and busy stays low. A scanning query reads its window of points
// from the start index on, wrapping at the path end: the point memory
// read port and the shared distance datapath handle one point per cycle,
// then three pipeline stages drain. Busy is high for the whole scan.
// Reset is synchronous; the point memory is not cleared. The receiver
// cannot stall, so each result is held for exactly one cycle.
module windowed_nearest_path_point_unit
   import wnpp_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [IDX_W-1:0]             req_load_index,
   input  logic [IDX_W-1:0]             req_start_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   // result
   output logic                         rsp_valid,
   output logic [IDX_W-1:0]             rsp_nearest_index,
   output logic [STATUS_W-1:0]          rsp_status,
   // configuration
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CFG_W-1:0]             csr_wdata
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   // internal index width: holds MAX_POINTS itself and any register value
   localparam int IW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
   localparam int CB = COORD_BITS;
   localparam int SQ_W = 2 * CB;
   localparam int DS_W = SQ_W + 1;
   localparam logic [IW-1:0] MAXP = IW'(MAX_POINTS);

   // |a - b| of two signed coordinates; always fits CB bits unsigned
   function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                              input logic [CB-1:0] b);
      logic [CB:0] d;
      logic [CB:0] m;
      d = {a[CB-1], a} - {b[CB-1], b};
      m = d[CB] ? (~d + 1'b1) : d;
      return m[CB-1:0];
   endfunction

   // point memory
   logic [CB-1:0] mem_x [MAX_POINTS];
   logic [CB-1:0] mem_y [MAX_POINTS];

   // control state
   seq_state_type  state_ff, state_in;
   logic [CFG_W-1:0] path_length_ff, path_length_in;
   logic [CFG_W-1:0] window_ff, window_in;
   logic [IW-1:0]  cnt_ff, cnt_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  len_ff, len_in;
   logic           have_ff, have_in;
   logic           v1_ff, v1_in;
   logic           v2_ff, v2_in;
   logic           v3_ff, v3_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CB-1:0]   vx_ff, vx_in;
   logic [CB-1:0]   vy_ff, vy_in;
   logic [CB-1:0]   rd_x_ff, rd_y_ff;
   logic [IW-1:0]   i1_ff, i2_ff, i3_ff;
   logic [CB-1:0]   dx_ff, dx_in;
   logic [CB-1:0]   dy_ff, dy_in;
   logic [SQ_W-1:0] sqx_ff, sqx_in;
   logic [SQ_W-1:0] sqy_ff, sqy_in;
   logic [DS_W-1:0] best_dist_ff, best_dist_in;
   logic [IW-1:0]   best_ff, best_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic            accept;
   logic            rd_en;
   logic            store_we;
   logic [IW-1:0]   plen_ext;
   logic [IW-1:0]   win_ext;
   logic [IW-1:0]   len_now;
   logic [IW-1:0]   win_now;
   logic [IW-1:0]   start_ext;
   logic [IW-1:0]   load_ext;
   logic [IW-1:0]   idx_inc;
   logic [DS_W-1:0] dist_sum;
   logic            pipe_empty;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rd_en      = (state_ff == ST_SCAN);
   assign pipe_empty = !v1_ff && !v2_ff && !v3_ff;

   // effective length and window for a new query
   assign plen_ext  = IW'(path_length_ff);
   assign win_ext   = IW'(window_ff);
   assign len_now   = (plen_ext > MAXP) ? MAXP : plen_ext;
   assign win_now   = (win_ext > len_now) ? len_now : win_ext;
   assign start_ext = IW'(req_start_index);
   assign load_ext  = IW'(req_load_index);
   assign store_we  = accept && (req_type == REQ_STORE) && (load_ext < MAXP);

   // ring step
   assign idx_inc = (idx_ff + 1'b1 == len_ff) ? '0 : idx_ff + 1'b1;

   // distance datapath: diff, square, sum
   assign dx_in    = abs_diff(rd_x_ff, vx_ff);
   assign dy_in    = abs_diff(rd_y_ff, vy_ff);
   assign sqx_in   = {{CB{1'b0}}, dx_ff} * {{CB{1'b0}}, dx_ff};
   assign sqy_in   = {{CB{1'b0}}, dy_ff} * {{CB{1'b0}}, dy_ff};
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // configuration writes
   always_comb begin
      path_length_in = path_length_ff;
      window_in      = window_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATH_LENGTH:   path_length_in = csr_wdata;
            CSR_SEARCH_WINDOW: window_in      = csr_wdata;
            default:           path_length_in = path_length_ff;
         endcase
      end
   end

   // sequencer and running minimum
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      v1_in         = rd_en;
      v2_in         = v1_ff;
      v3_in         = v2_ff;

      // compare stage; the first point of a scan always wins
      if (v3_ff && (!have_ff || (dist_sum < best_dist_ff))) begin
         have_in      = 1'b1;
         best_in      = i3_ff;
         best_dist_in = dist_sum;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_index_in  = '0;
               rsp_status_in = STATUS_BAD;
               if (req_type == REQ_STORE) begin
                  rsp_valid_in = 1'b1;
                  if (load_ext < MAXP) begin
                     rsp_status_in = STATUS_STORED;
                  end
               end else if ((len_now == '0) || (start_ext >= len_now)) begin
                  rsp_valid_in = 1'b1;
               end else if (win_now == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = req_start_index;
                  rsp_status_in = STATUS_DONE;
               end else begin
                  state_in = ST_SCAN;
                  cnt_in   = win_now;
                  idx_in   = start_ext;
                  len_in   = len_now;
                  vx_in    = req_coord_x;
                  vy_in    = req_coord_y;
                  have_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_inc;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == IW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = best_ff[IDX_W-1:0];
               rsp_status_in = STATUS_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         path_length_ff <= RST_PATH_LENGTH;
         window_ff      <= RST_SEARCH_WINDOW;
         cnt_ff         <= '0;
         idx_ff         <= '0;
         len_ff         <= '0;
         have_ff        <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         path_length_ff <= path_length_in;
         window_ff      <= window_in;
         cnt_ff         <= cnt_in;
         idx_ff         <= idx_in;
         len_ff         <= len_in;
         have_ff        <= have_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         v3_ff          <= v3_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      i1_ff         <= idx_ff;
      i2_ff         <= i1_ff;
      i3_ff         <= i2_ff;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      best_ff       <= best_in;
      best_dist_ff  <= best_dist_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   // point memory write
   always_ff @(posedge clock) begin
      if (store_we) begin
         mem_x[load_ext[AW-1:0]] <= req_coord_x;
         mem_y[load_ext[AW-1:0]] <= req_coord_y;
      end
   end

   // point memory read, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_x_ff <= mem_x[idx_ff[AW-1:0]];
         rd_y_ff <= mem_y[idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_status        = rsp_status_ff;

   // no result while points are still being issued
   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result issued during scan");

   // the winning index lies on the path
   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && pipe_empty) |-> (have_ff && (best_ff < len_ff)))
      else $error("nearest index outside path");

   // compare stage only fires during a query
   a_pipe_in_query: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("distance pipeline active while idle");

   // a scan only begins on an accepted query
   a_busy_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(start) && ($past(req_type) == REQ_QUERY)))
      else $error("scan started without a query");

endmodule
